/* sv/tbat_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbat_pkg
// Shared types, codes and helpers for the texture bump allocator table.
// ----------------------------------------------------------------------------
package tbat_pkg;

  localparam int MAX_ENTRIES_DEF = 64;

  localparam int KEY_W     = 16;
  localparam int FMT_W     = 4;
  localparam int DIM_W     = 10;
  localparam int ADDR_W    = 32;
  localparam int BYTES_W   = 25;
  localparam int TEXELS_W  = 2 * DIM_W;
  localparam int SIZE_W    = TEXELS_W + 2;
  localparam int INFO_W    = FMT_W + 2 * DIM_W + ADDR_W;
  localparam int ENTRY_W   = KEY_W + INFO_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  typedef logic [CFG_IDX_W-1:0] cfg_index_t;

  localparam cfg_index_t REG_MEMORY_BASE    = 2'd0;
  localparam cfg_index_t REG_MEMORY_BYTES   = 2'd1;
  localparam cfg_index_t REG_RESERVED_BYTES = 2'd2;

  localparam logic ACT_STORE  = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  localparam logic [FMT_W-1:0] FMT_565  = 4'd0;
  localparam logic [FMT_W-1:0] FMT_5551 = 4'd1;
  localparam logic [FMT_W-1:0] FMT_4444 = 4'd2;
  localparam logic [FMT_W-1:0] FMT_8888 = 4'd3;
  localparam logic [FMT_W-1:0] FMT_T4   = 4'd4;
  localparam logic [FMT_W-1:0] FMT_T8   = 4'd5;

  localparam logic [ADDR_W-1:0]  MEMORY_BASE_RST    = 32'h0400_0000;
  localparam logic [BYTES_W-1:0] MEMORY_BYTES_RST   = 25'd2097152;
  localparam logic [BYTES_W-1:0] RESERVED_BYTES_RST = 25'd0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHECK,
    ST_SCAN,
    ST_DONE
  } state_t;

  function automatic logic [SIZE_W-1:0] texture_bytes(
    input logic [FMT_W-1:0]    fmt,
    input logic [TEXELS_W-1:0] texels
  );
    logic [SIZE_W-1:0] size;
    case (fmt)
      FMT_565, FMT_5551, FMT_4444: size = {1'b0, texels, 1'b0};
      FMT_8888:                    size = {texels, 2'b00};
      FMT_T4:                      size = {3'b000, texels[TEXELS_W-1:1]};
      FMT_T8:                      size = {2'b00, texels};
      default:                     size = '0;
    endcase
    return size;
  endfunction

endpackage

/* sv/tbat_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbat_if
// Request and response channels of the texture bump allocator table.
// ----------------------------------------------------------------------------
interface tbat_req_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [tbat_pkg::KEY_W-1:0]  texture_key;
  logic [tbat_pkg::FMT_W-1:0]  pixel_format;
  logic [tbat_pkg::DIM_W-1:0]  tex_width;
  logic [tbat_pkg::DIM_W-1:0]  tex_height;

  modport source (
    output valid, action, texture_key, pixel_format, tex_width, tex_height,
    input  ready
  );
  modport sink (
    input  valid, action, texture_key, pixel_format, tex_width, tex_height,
    output ready
  );
endinterface

interface tbat_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        ok;
  logic [tbat_pkg::FMT_W-1:0]  found_format;
  logic [tbat_pkg::DIM_W-1:0]  found_width;
  logic [tbat_pkg::DIM_W-1:0]  found_height;
  logic [tbat_pkg::ADDR_W-1:0] found_address;

  modport source (
    output valid, ok, found_format, found_width, found_height, found_address,
    input  ready
  );
  modport sink (
    input  valid, ok, found_format, found_width, found_height, found_address,
    output ready
  );
endinterface

/* sv/tbat_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbat_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tbat_ram #(
  parameter  int WIDTH  = 8,
  parameter  int DEPTH  = 64,
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/texture_bump_allocator_table_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// texture_bump_allocator_table_core
// Bump allocator for texture memory with a key table held in one RAM.
// Store: shift-add multiply of width by height (one step per height bit,
//   until the remaining bits are zero), then a check, then the response register.
// Lookup: table scanned newest first, one entry per cycle through the RAM
//   read port; a lookup on an empty table skips the scan.
// One item at a time; next request taken in the cycle after the reply loads.
// Reset: synchronous; control and configuration registers to defaults, table empty, no clearing pass.
// ----------------------------------------------------------------------------
module texture_bump_allocator_table_core #(
  parameter int MAX_ENTRIES = tbat_pkg::MAX_ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  tbat_pkg::cfg_index_t            wr_index,
  input  logic [tbat_pkg::CFG_DATA_W-1:0] wr_data,
  tbat_req_if.sink                        req,
  tbat_rsp_if.source                      rsp
);

  import tbat_pkg::*;

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  state_t state, state_next;

  logic [ADDR_W-1:0]  memory_base;
  logic [BYTES_W-1:0] memory_bytes;
  logic [BYTES_W-1:0] reserved_bytes;
  logic [ADDR_W-1:0]  next_address;
  logic [BYTES_W-1:0] free_bytes;
  logic [CNT_W-1:0]   entry_count;

  logic [KEY_W-1:0]    key;
  logic [FMT_W-1:0]    fmt;
  logic [DIM_W-1:0]    width;
  logic [DIM_W-1:0]    height;
  logic [TEXELS_W-1:0] mcand;
  logic [DIM_W-1:0]    mplr;
  logic [TEXELS_W-1:0] acc;

  logic [IDX_W-1:0] issue_idx;
  logic             issue_more;
  logic             pend;
  logic             pend_last;

  logic              hold_ok;
  logic [INFO_W-1:0] hold_info;

  logic [ADDR_W-1:0]  base_w;
  logic [BYTES_W-1:0] bytes_w;
  logic [BYTES_W-1:0] reserved_w;
  logic               cfg_hit;
  logic [ADDR_W-1:0]  restart_address;
  logic [BYTES_W-1:0] restart_free;

  logic [SIZE_W-1:0] size;
  logic              store_ok;
  logic              accept;
  logic              load_out;
  logic              ram_we;
  logic [ENTRY_W-1:0] ram_rdata;
  logic              ram_match;
  logic [ADDR_W-1:0] pool_end;

  // configuration write and pointer restart
  always_comb begin
    base_w     = memory_base;
    bytes_w    = memory_bytes;
    reserved_w = reserved_bytes;
    cfg_hit    = 1'b0;
    if (wr_en) begin
      case (wr_index)
        REG_MEMORY_BASE: begin
          base_w  = wr_data;
          cfg_hit = 1'b1;
        end
        REG_MEMORY_BYTES: begin
          bytes_w = wr_data[BYTES_W-1:0];
          cfg_hit = 1'b1;
        end
        REG_RESERVED_BYTES: begin
          reserved_w = wr_data[BYTES_W-1:0];
          cfg_hit    = 1'b1;
        end
        default: cfg_hit = 1'b0;
      endcase
    end
    restart_address = base_w + ADDR_W'(reserved_w);
    restart_free    = (bytes_w >= reserved_w) ? (bytes_w - reserved_w) : '0;
  end

  assign size      = texture_bytes(fmt, acc);
  assign store_ok  = (BYTES_W'(size) <= free_bytes) && (entry_count < CNT_W'(MAX_ENTRIES));
  assign accept    = req.valid && req.ready;
  assign ram_match = pend && (ram_rdata[ENTRY_W-1 -: KEY_W] == key);
  assign pool_end  = next_address + ADDR_W'(free_bytes);

  tbat_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (entry_count[IDX_W-1:0]),
    .wdata ({key, fmt, width, height, next_address}),
    .raddr (issue_idx),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (req.action == ACT_STORE) begin
            state_next = ST_MUL;
          end else if (entry_count == '0) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_MUL: begin
        if (mplr == '0) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: state_next = ST_DONE;
      ST_SCAN: begin
        if (pend && (ram_match || pend_last)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!rsp.valid || rsp.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req.ready = 1'b0;
    ram_we    = 1'b0;
    load_out  = 1'b0;
    case (state)
      ST_IDLE:  req.ready = 1'b1;
      ST_CHECK: ram_we    = store_ok;
      ST_DONE:  load_out  = !rsp.valid || rsp.ready;
      default: begin
        req.ready = 1'b0;
      end
    endcase
  end

  // control and allocator state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      memory_base    <= MEMORY_BASE_RST;
      memory_bytes   <= MEMORY_BYTES_RST;
      reserved_bytes <= RESERVED_BYTES_RST;
      next_address   <= MEMORY_BASE_RST + ADDR_W'(RESERVED_BYTES_RST);
      free_bytes     <= MEMORY_BYTES_RST - RESERVED_BYTES_RST;
      entry_count    <= '0;
      issue_more     <= 1'b0;
      pend           <= 1'b0;
      pend_last      <= 1'b0;
      rsp.valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_hit) begin
        memory_base    <= base_w;
        memory_bytes   <= bytes_w;
        reserved_bytes <= reserved_w;
        next_address   <= restart_address;
        free_bytes     <= restart_free;
      end else if (ram_we) begin
        next_address <= next_address + ADDR_W'(size);
        free_bytes   <= free_bytes - BYTES_W'(size);
      end
      if (ram_we) begin
        entry_count <= entry_count + CNT_W'(1);
      end
      if (accept) begin
        issue_more <= 1'b1;
        pend       <= 1'b0;
        pend_last  <= 1'b0;
      end else if (state == ST_SCAN) begin
        pend      <= issue_more;
        pend_last <= issue_more && (issue_idx == '0);
        if (issue_more && (issue_idx == '0)) begin
          issue_more <= 1'b0;
        end
      end
      if (load_out) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      key       <= req.texture_key;
      fmt       <= req.pixel_format;
      width     <= req.tex_width;
      height    <= req.tex_height;
      mcand     <= TEXELS_W'(req.tex_width);
      mplr      <= req.tex_height;
      acc       <= '0;
      issue_idx <= IDX_W'(entry_count - CNT_W'(1));
      hold_ok   <= 1'b0;
      hold_info <= '0;
    end else begin
      case (state)
        ST_MUL: begin
          if (mplr[0]) begin
            acc <= acc + mcand;
          end
          mcand <= {mcand[TEXELS_W-2:0], 1'b0};
          mplr  <= {1'b0, mplr[DIM_W-1:1]};
        end
        ST_CHECK: begin
          hold_ok   <= store_ok;
          hold_info <= store_ok ? {fmt, width, height, next_address} : '0;
        end
        ST_SCAN: begin
          if (issue_more && (issue_idx != '0)) begin
            issue_idx <= issue_idx - IDX_W'(1);
          end
          if (ram_match) begin
            hold_ok   <= 1'b1;
            hold_info <= ram_rdata[INFO_W-1:0];
          end
        end
        default: begin
          acc <= acc;
        end
      endcase
    end
    if (load_out) begin
      rsp.ok            <= hold_ok;
      rsp.found_format  <= hold_info[INFO_W-1 -: FMT_W];
      rsp.found_width   <= hold_info[ADDR_W+2*DIM_W-1 -: DIM_W];
      rsp.found_height  <= hold_info[ADDR_W+DIM_W-1 -: DIM_W];
      rsp.found_address <= hold_info[ADDR_W-1:0];
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(MAX_ENTRIES))
    else $error("entry count beyond table depth");

  a_store_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHECK && store_ok) |=> (entry_count == $past(entry_count) + CNT_W'(1)))
    else $error("accepted store did not add a table entry");

  a_scan_miss: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && pend && pend_last && !ram_match) |=> (state == ST_DONE && !hold_ok))
    else $error("scan miss did not finish with a failed result");

  a_pool_end: assert property (@(posedge clk) disable iff (rst)
    !wr_en |=> (pool_end == $past(pool_end)))
    else $error("allocation lost or gained bytes");

endmodule
